FILE: rtl/core/bzd_pkg.sv
// Shared constants and codes for the cubic Bezier derivative evaluator.
package bzd_pkg;

   // Fixed field widths of the ports.
   localparam int CMD_W     = 3;
   localparam int PARAM_W   = 18;
   localparam int OUT_W     = 28;
   localparam int CFG_W     = 60;
   localparam int CSR_IDX_W = 2;

   // One lane for each of x, y and z.
   localparam int LANES = 3;

   // Headroom of the polynomial coefficients over the coordinate width.
   localparam int COEF_EXTRA = 6;

   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // Derivative order; the remaining codes give a zero vector.
   typedef enum logic [CMD_W-1:0] {
      ORD_POS  = 3'd0,
      ORD_VEL  = 3'd1,
      ORD_ACC  = 3'd2,
      ORD_JERK = 3'd3
   } order_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POINT_ZERO  = 2'd0,
      REG_POINT_ONE   = 2'd1,
      REG_POINT_TWO   = 2'd2,
      REG_POINT_THREE = 2'd3
   } csr_reg_type;

endpackage

FILE: rtl/core/bzd_coef.sv
// Power-basis coefficients of one coordinate lane, selected by derivative order.
module bzd_coef #(
   parameter int COORD_BITS = 20
) (
   input  logic                                      clock,
   input  logic signed [COORD_BITS-1:0]              pt0,
   input  logic signed [COORD_BITS-1:0]              pt1,
   input  logic signed [COORD_BITS-1:0]              pt2,
   input  logic signed [COORD_BITS-1:0]              pt3,
   input  logic [bzd_pkg::CMD_W-1:0]                 cmd,
   output logic signed [COORD_BITS+bzd_pkg::COEF_EXTRA-1:0] c0,
   output logic signed [COORD_BITS+bzd_pkg::COEF_EXTRA-1:0] c1,
   output logic signed [COORD_BITS+bzd_pkg::COEF_EXTRA-1:0] c2,
   output logic signed [COORD_BITS+bzd_pkg::COEF_EXTRA-1:0] c3
);

   localparam int CW = COORD_BITS + bzd_pkg::COEF_EXTRA;
   localparam int XW = bzd_pkg::COEF_EXTRA;

   logic signed [CW-1:0] p0e, p1e, p2e, p3e;
   logic signed [CW-1:0] d10, s2, d12;
   logic signed [CW-1:0] a1_in, a2_in, a3_in, p0_in;
   logic signed [CW-1:0] a1_ff, a2_ff, a3_ff, p0_ff;
   logic signed [CW-1:0] a3x6;
   logic signed [CW-1:0] c0_in, c1_in, c2_in, c3_in;
   logic signed [CW-1:0] c0_ff, c1_ff, c2_ff, c3_ff;

   assign p0e = {{XW{pt0[COORD_BITS-1]}}, pt0};
   assign p1e = {{XW{pt1[COORD_BITS-1]}}, pt1};
   assign p2e = {{XW{pt2[COORD_BITS-1]}}, pt2};
   assign p3e = {{XW{pt3[COORD_BITS-1]}}, pt3};

   // a1 = 3(P1-P0), a2 = 3(P0-2P1+P2), a3 = P3-3P2+3P1-P0.
   assign d10   = p1e - p0e;
   assign s2    = p0e - (p1e <<< 1) + p2e;
   assign d12   = p1e - p2e;
   assign a1_in = d10 + (d10 <<< 1);
   assign a2_in = s2 + (s2 <<< 1);
   assign a3_in = (p3e - p0e) + d12 + (d12 <<< 1);
   assign p0_in = p0e;

   assign a3x6 = (a3_ff <<< 1) + (a3_ff <<< 2);

   always_comb begin
      c0_in = '0;
      c1_in = '0;
      c2_in = '0;
      c3_in = '0;
      unique case (cmd)
         bzd_pkg::ORD_POS: begin
            c0_in = p0_ff;
            c1_in = a1_ff;
            c2_in = a2_ff;
            c3_in = a3_ff;
         end
         bzd_pkg::ORD_VEL: begin
            c0_in = a1_ff;
            c1_in = a2_ff <<< 1;
            c2_in = a3_ff + (a3_ff <<< 1);
         end
         bzd_pkg::ORD_ACC: begin
            c0_in = a2_ff <<< 1;
            c1_in = a3x6;
         end
         bzd_pkg::ORD_JERK: begin
            c0_in = a3x6;
         end
         default: begin
            c0_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a1_ff <= a1_in;
      a2_ff <= a2_in;
      a3_ff <= a3_in;
      p0_ff <= p0_in;
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      c3_ff <= c3_in;
   end

   assign c0 = c0_ff;
   assign c1 = c1_ff;
   assign c2 = c2_ff;
   assign c3 = c3_ff;

endmodule

FILE: rtl/core/bzd_mac.sv
// One Horner step for all lanes: acc * s + addend, split into two partial products.
module bzd_mac #(
   parameter int AW = 26,
   parameter int SW = 17,
   parameter int OW = 43
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  logic [SW-1:0]        s_in,
   input  logic signed [AW-1:0] acc_in [bzd_pkg::LANES],
   input  logic signed [OW-1:0] add_in [bzd_pkg::LANES],
   output logic                 valid_out,
   output logic [SW-1:0]        s_out,
   output logic signed [OW-1:0] acc_out [bzd_pkg::LANES]
);

   localparam int LO  = AW / 2;
   localparam int HI  = AW - LO;
   localparam int PLW = LO + SW;
   localparam int PHW = HI + SW + 1;

   logic                 valid_a_ff, valid_a_in;
   logic [SW-1:0]        s_a_ff, s_a_in;
   logic [PLW-1:0]       pp_lo_ff [bzd_pkg::LANES];
   logic [PLW-1:0]       pp_lo_in [bzd_pkg::LANES];
   logic signed [PHW-1:0] pp_hi_ff [bzd_pkg::LANES];
   logic signed [PHW-1:0] pp_hi_in [bzd_pkg::LANES];
   logic signed [PHW-1:0] hi_ext [bzd_pkg::LANES];
   logic signed [PHW-1:0] s_ext;
   logic signed [OW-1:0] add_a_ff [bzd_pkg::LANES];
   logic signed [OW-1:0] add_a_in [bzd_pkg::LANES];
   logic                 valid_b_ff, valid_b_in;
   logic [SW-1:0]        s_b_ff, s_b_in;
   logic signed [OW-1:0] acc_b_ff [bzd_pkg::LANES];
   logic signed [OW-1:0] acc_b_in [bzd_pkg::LANES];

   assign s_ext      = {{(PHW-SW){1'b0}}, s_in};
   assign valid_a_in = valid_in;
   assign s_a_in     = s_in;
   assign valid_b_in = valid_a_ff;
   assign s_b_in     = s_a_ff;

   for (genvar l = 0; l < bzd_pkg::LANES; l++) begin : g_lane
      assign hi_ext[l]   = {{(PHW-HI){acc_in[l][AW-1]}}, acc_in[l][AW-1:LO]};
      assign pp_lo_in[l] = PLW'(acc_in[l][LO-1:0]) * PLW'(s_in);
      assign pp_hi_in[l] = hi_ext[l] * s_ext;
      assign add_a_in[l] = add_in[l];
      // The high product is weighted by 2^LO; the sum is exact in OW bits.
      assign acc_b_in[l] = {pp_hi_ff[l][OW-LO-1:0], {LO{1'b0}}}
                         + {{HI{1'b0}}, pp_lo_ff[l]}
                         + add_a_ff[l];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      s_a_ff   <= s_a_in;
      s_b_ff   <= s_b_in;
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      add_a_ff <= add_a_in;
      acc_b_ff <= acc_b_in;
   end

   assign valid_out = valid_b_ff;
   assign s_out     = s_b_ff;
   assign acc_out   = acc_b_ff;

endmodule

FILE: rtl/core/cubic_bezier_derivative_eval.sv
// Top level of the pipelined cubic Bezier curve and derivative evaluator.
//
// Usage: the four control points are written through the csr_ channel
// (csr_index 0 to 3 selects start point, inner points and end point; each
// word packs x, y and z as signed coordinates with eight fraction bits).
// csr_ready is always high; the points must only be changed while no
// transaction is in flight.
// A request transaction is taken at each rising edge with start high and
// busy low. busy is always low, so one transaction can be taken in every
// cycle, and a result leaves in every cycle at full rate.
// A transaction taken at a rising edge is presented on rsp_out_x, rsp_out_y
// and rsp_out_z with rsp_valid high once it has passed the pipeline: one
// register stage for coefficient preparation and parameter clamping, one
// for order selection, three Horner multiply-add steps of two stages each,
// and the output rounding register.
// The receiver cannot hold results off: rsp_valid is a one-cycle strobe.
// Synchronous reset empties the pipeline and clears the control points.
module cubic_bezier_derivative_eval #(
   parameter int COORD_BITS  = 20,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [bzd_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [bzd_pkg::PARAM_W-1:0]   req_param_t,
   output logic                                 rsp_valid,
   output logic signed [bzd_pkg::OUT_W-1:0]     rsp_out_x,
   output logic signed [bzd_pkg::OUT_W-1:0]     rsp_out_y,
   output logic signed [bzd_pkg::OUT_W-1:0]     rsp_out_z,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bzd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bzd_pkg::CFG_W-1:0]            csr_wdata
);

   localparam int LANES = bzd_pkg::LANES;
   localparam int PW    = bzd_pkg::PARAM_W;
   localparam int OUT_W = bzd_pkg::OUT_W;
   // Coefficient width, width of the clamped parameter and accumulator widths.
   localparam int CW    = COORD_BITS + bzd_pkg::COEF_EXTRA;
   localparam int SW    = T_FRAC_BITS + 1;
   localparam int A1    = CW + SW;
   localparam int A2    = A1 + SW;
   localparam int A3    = A2 + SW;
   // The final shift drops 3*T_FRAC_BITS fraction bits of t^3.
   localparam int SHR   = 3 * T_FRAC_BITS;
   localparam int RW    = A3 - SHR;
   localparam int CMPW  = (PW > T_FRAC_BITS + 2) ? PW : T_FRAC_BITS + 2;
   localparam logic [CMPW-1:0] T_ONE = CMPW'(1) << T_FRAC_BITS;
   localparam int C1_DLY  = 2;
   localparam int C0_DLY  = 4;
   localparam int LATENCY = 9;

   // Control point registers.
   logic [bzd_pkg::CFG_W-1:0] point_ff [4];
   logic [bzd_pkg::CFG_W-1:0] point_in [4];

   // Stage 0: accepted transaction, with the parameter clamped to [0, 1].
   logic                       accept;
   logic                       s0_valid_ff, s0_valid_in;
   logic [SW-1:0]              s0_s_ff, s0_s_in;
   logic [bzd_pkg::CMD_W-1:0]  s0_cmd_ff, s0_cmd_in;
   logic [CMPW-1:0]            t_mag;

   // Stage 1: selected coefficients (held in the lane units).
   logic                       sel_valid_ff, sel_valid_in;
   logic [SW-1:0]              sel_s_ff, sel_s_in;
   logic signed [CW-1:0]       c0_sel [LANES];
   logic signed [CW-1:0]       c1_sel [LANES];
   logic signed [CW-1:0]       c2_sel [LANES];
   logic signed [CW-1:0]       c3_sel [LANES];

   // Lower coefficients wait for the Horner step that adds them in.
   logic signed [CW-1:0]       c1_dly_ff [C1_DLY][LANES];
   logic signed [CW-1:0]       c1_dly_in [C1_DLY][LANES];
   logic signed [CW-1:0]       c0_dly_ff [C0_DLY][LANES];
   logic signed [CW-1:0]       c0_dly_in [C0_DLY][LANES];

   logic signed [A1-1:0]       add1 [LANES];
   logic signed [A2-1:0]       add2 [LANES];
   logic signed [A3-1:0]       add3 [LANES];
   logic signed [A1-1:0]       acc1 [LANES];
   logic signed [A2-1:0]       acc2 [LANES];
   logic signed [A3-1:0]       acc3 [LANES];
   logic                       m1_valid, m2_valid, m3_valid;
   logic [SW-1:0]              m1_s, m2_s;

   // Output stage.
   logic signed [RW-1:0]       rnd [LANES];
   logic signed [OUT_W-1:0]    rsp_in [LANES];
   logic signed [OUT_W-1:0]    rsp_ff [LANES];
   logic                       rsp_valid_ff, rsp_valid_in;

   // The pipeline never stalls, so a transaction is taken whenever offered.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Configuration writes.
   always_comb begin
      point_in = point_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bzd_pkg::REG_POINT_ZERO:  point_in[0] = csr_wdata;
            bzd_pkg::REG_POINT_ONE:   point_in[1] = csr_wdata;
            bzd_pkg::REG_POINT_TWO:   point_in[2] = csr_wdata;
            bzd_pkg::REG_POINT_THREE: point_in[3] = csr_wdata;
            default:                  point_in = point_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            point_ff[i] <= '0;
         end
      end else begin
         point_ff <= point_in;
      end
   end

   // Parameter clamp: negative values become zero, values above one become one.
   assign t_mag = CMPW'(req_param_t[PW-2:0]);

   always_comb begin
      if (req_param_t[PW-1]) begin
         s0_s_in = '0;
      end else if (t_mag > T_ONE) begin
         s0_s_in = T_ONE[SW-1:0];
      end else begin
         s0_s_in = t_mag[SW-1:0];
      end
   end

   assign s0_valid_in  = accept;
   assign s0_cmd_in    = req_cmd;
   assign sel_valid_in = s0_valid_ff;
   assign sel_s_in     = s0_s_ff;

   // Coefficient units, one for each of x, y and z. Their first register
   // follows the control points, so a transaction taken at the edge of a
   // write still sees the points as they were before it.
   for (genvar l = 0; l < LANES; l++) begin : g_coef
      bzd_coef #(
         .COORD_BITS (COORD_BITS)
      ) u_coef (
         .clock (clock),
         .pt0   (point_ff[0][l*COORD_BITS +: COORD_BITS]),
         .pt1   (point_ff[1][l*COORD_BITS +: COORD_BITS]),
         .pt2   (point_ff[2][l*COORD_BITS +: COORD_BITS]),
         .pt3   (point_ff[3][l*COORD_BITS +: COORD_BITS]),
         .cmd   (s0_cmd_ff),
         .c0    (c0_sel[l]),
         .c1    (c1_sel[l]),
         .c2    (c2_sel[l]),
         .c3    (c3_sel[l])
      );
   end

   // Delay lines for the coefficients that enter later Horner steps.
   always_comb begin
      c1_dly_in[0] = c1_sel;
      c0_dly_in[0] = c0_sel;
      for (int d = 1; d < C1_DLY; d++) begin
         c1_dly_in[d] = c1_dly_ff[d-1];
      end
      for (int d = 1; d < C0_DLY; d++) begin
         c0_dly_in[d] = c0_dly_ff[d-1];
      end
   end

   always_ff @(posedge clock) begin
      c1_dly_ff <= c1_dly_in;
      c0_dly_ff <= c0_dly_in;
   end

   // Horner addends. Each coefficient is scaled by the power of 2^T_FRAC_BITS
   // that keeps the sum exact. The last addend also carries one half of the
   // output unit, so that the final arithmetic shift rounds to nearest with
   // ties towards plus infinity.
   for (genvar l = 0; l < LANES; l++) begin : g_add
      assign add1[l] = {{(A1-CW-T_FRAC_BITS){c2_sel[l][CW-1]}}, c2_sel[l],
                        {T_FRAC_BITS{1'b0}}};
      assign add2[l] = {{(A2-CW-2*T_FRAC_BITS){c1_dly_ff[C1_DLY-1][l][CW-1]}},
                        c1_dly_ff[C1_DLY-1][l], {(2*T_FRAC_BITS){1'b0}}};
      assign add3[l] = {{(A3-CW-SHR){c0_dly_ff[C0_DLY-1][l][CW-1]}},
                        c0_dly_ff[C0_DLY-1][l], 1'b1, {(SHR-1){1'b0}}};
   end

   // Three Horner steps: ((c3 s + c2 R) s + c1 R^2) s + c0 R^3 + R^3/2.
   bzd_mac #(
      .AW (CW),
      .SW (SW),
      .OW (A1)
   ) u_mac1 (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sel_valid_ff),
      .s_in      (sel_s_ff),
      .acc_in    (c3_sel),
      .add_in    (add1),
      .valid_out (m1_valid),
      .s_out     (m1_s),
      .acc_out   (acc1)
   );

   bzd_mac #(
      .AW (A1),
      .SW (SW),
      .OW (A2)
   ) u_mac2 (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (m1_valid),
      .s_in      (m1_s),
      .acc_in    (acc1),
      .add_in    (add2),
      .valid_out (m2_valid),
      .s_out     (m2_s),
      .acc_out   (acc2)
   );

   bzd_mac #(
      .AW (A2),
      .SW (SW),
      .OW (A3)
   ) u_mac3 (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (m2_valid),
      .s_in      (m2_s),
      .acc_in    (acc2),
      .add_in    (add3),
      .valid_out (m3_valid),
      .s_out     (),
      .acc_out   (acc3)
   );

   // Rounding shift and saturation to the output range.
   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign rnd[l] = acc3[l][A3-1:SHR];
      if (RW > OUT_W) begin : g_sat
         logic [RW-OUT_W:0] upper;
         assign upper = rnd[l][RW-1:OUT_W-1];
         always_comb begin
            if ((&upper) || !(|upper)) begin
               rsp_in[l] = rnd[l][OUT_W-1:0];
            end else if (rnd[l][RW-1]) begin
               rsp_in[l] = bzd_pkg::OUT_MIN;
            end else begin
               rsp_in[l] = bzd_pkg::OUT_MAX;
            end
         end
      end else begin : g_ext
         assign rsp_in[l] = OUT_W'(rnd[l]);
      end
   end

   assign rsp_valid_in = m3_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         sel_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         sel_valid_ff <= sel_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_s_ff   <= s0_s_in;
      s0_cmd_ff <= s0_cmd_in;
      sel_s_ff  <= sel_s_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_ff[0];
   assign rsp_out_y = rsp_ff[1];
   assign rsp_out_z = rsp_ff[2];

`ifndef ASSERT_OFF
   // Every accepted transaction produces exactly one result strobe.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result strobe");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without an accepted transaction");

   // Orders above three give a zero vector.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_cmd[2], LATENCY) |->
         (rsp_out_x == '0) && (rsp_out_y == '0) && (rsp_out_z == '0))
      else $error("order above three gave a non-zero result");

   // The pipeline valid bits never outrun the accepted transactions.
   assert property (@(posedge clock) disable iff (reset)
      sel_valid_ff |-> $past(s0_valid_ff))
      else $error("selection stage valid without a stage zero transaction");
`endif

endmodule

FILE: dv/cubic_bezier_derivative_eval_tb.sv
// Self-checking testbench for the cubic Bezier curve and derivative evaluator.
module cubic_bezier_derivative_eval_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // The block is built at its default sizes, and the predictor below is
   // written for the same sizes.
   localparam int COORD_BITS  = 20;
   localparam int T_FRAC_BITS = 16;

   // A margin is allowed after the last owed result has come back, before
   // the control points are touched or the run is ended.
   localparam int DRAIN_CYCLES = 12;

   // Exact arithmetic is carried in 128-bit signed words. One is the
   // parameter scale, 2^T_FRAC_BITS, and the limits are those of the
   // signed 28-bit result ports.
   localparam logic signed [127:0] T_ONE   = 128'sd1 <<< T_FRAC_BITS;
   localparam logic signed [127:0] SAT_HI  = (128'sd1 <<< (bzd_pkg::OUT_W - 1)) - 128'sd1;
   localparam logic signed [127:0] SAT_LO  = -(128'sd1 <<< (bzd_pkg::OUT_W - 1));

   // Coordinate extremes used to build corner-case control points.
   localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [COORD_BITS-1:0] COORD_NEG = {COORD_BITS{1'b1}};

   typedef struct packed {
      logic signed [bzd_pkg::OUT_W-1:0] x;
      logic signed [bzd_pkg::OUT_W-1:0] y;
      logic signed [bzd_pkg::OUT_W-1:0] z;
   } curve_vec_type;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 start       = 1'b0;
   logic                                 busy;
   logic [bzd_pkg::CMD_W-1:0]            req_cmd     = '0;
   logic signed [bzd_pkg::PARAM_W-1:0]   req_param_t = '0;
   logic                                 rsp_valid;
   logic signed [bzd_pkg::OUT_W-1:0]     rsp_out_x;
   logic signed [bzd_pkg::OUT_W-1:0]     rsp_out_y;
   logic signed [bzd_pkg::OUT_W-1:0]     rsp_out_z;
   logic                                 csr_valid   = 1'b0;
   logic                                 csr_ready;
   logic [bzd_pkg::CSR_IDX_W-1:0]        csr_index   = '0;
   logic [bzd_pkg::CFG_W-1:0]            csr_wdata   = '0;

   // The testbench's own copy of the four control points, which are all
   // cleared by reset.
   logic [bzd_pkg::CFG_W-1:0]            ctrl_points [4] = '{default: '0};

   // Curve values still owed by the block, oldest first.
   curve_vec_type                        pending_curve_values [$];
   curve_vec_type                        owed_value;
   int                                   error_count = 0;

   cubic_bezier_derivative_eval #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .req_param_t (req_param_t),
      .rsp_valid   (rsp_valid),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A generous bound on the whole run; a correct run ends long before it.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Pulls one signed coordinate out of a packed control point.
   function automatic logic signed [127:0] point_coord(
         input logic [bzd_pkg::CFG_W-1:0] point,
         input int lane);
      logic signed [COORD_BITS-1:0] c;
      c = point[lane*COORD_BITS +: COORD_BITS];
      return c;
   endfunction

   // Evaluates c0 + c1 t + c2 t^2 + c3 t^3 exactly, with t = s / 2^T_FRAC_BITS,
   // and rounds once to the nearest result LSB, ties going upwards.
   function automatic logic signed [127:0] poly_round(input logic signed [127:0] c0,
                                                      input logic signed [127:0] c1,
                                                      input logic signed [127:0] c2,
                                                      input logic signed [127:0] c3,
                                                      input logic signed [127:0] s);
      logic signed [127:0] acc;
      acc = c3;
      acc = acc * s + c2 * T_ONE;
      acc = acc * s + c1 * T_ONE * T_ONE;
      acc = acc * s + c0 * T_ONE * T_ONE * T_ONE;
      acc = acc + (T_ONE >>> 1) * T_ONE * T_ONE;
      return acc >>> (3 * T_FRAC_BITS);
   endfunction

   function automatic logic signed [bzd_pkg::OUT_W-1:0] saturate(
         input logic signed [127:0] v);
      if (v > SAT_HI)
         return SAT_HI[bzd_pkg::OUT_W-1:0];
      if (v < SAT_LO)
         return SAT_LO[bzd_pkg::OUT_W-1:0];
      return v[bzd_pkg::OUT_W-1:0];
   endfunction

   // Works out the curve point or derivative that one request should give,
   // from the control points currently held.
   function automatic curve_vec_type curve_value(
         input logic [bzd_pkg::CMD_W-1:0] cmd,
         input logic signed [bzd_pkg::PARAM_W-1:0] t);
      logic signed [127:0] s;
      logic signed [127:0] p0, p1, p2, p3, a1, a2, a3, v;
      logic signed [bzd_pkg::OUT_W-1:0] lanes [bzd_pkg::LANES];
      // The parameter is clamped to the closed interval from zero to one.
      if (t < 0)
         s = 0;
      else if (t > T_ONE)
         s = T_ONE;
      else
         s = t;
      for (int j = 0; j < bzd_pkg::LANES; j++) begin
         p0 = point_coord(ctrl_points[bzd_pkg::REG_POINT_ZERO], j);
         p1 = point_coord(ctrl_points[bzd_pkg::REG_POINT_ONE], j);
         p2 = point_coord(ctrl_points[bzd_pkg::REG_POINT_TWO], j);
         p3 = point_coord(ctrl_points[bzd_pkg::REG_POINT_THREE], j);
         // Power-basis coefficients of the cubic.
         a1 = 3 * (p1 - p0);
         a2 = 3 * (p0 - 2 * p1 + p2);
         a3 = p3 - 3 * p2 + 3 * p1 - p0;
         case (bzd_pkg::order_type'(cmd))
            bzd_pkg::ORD_POS:  v = poly_round(p0, a1, a2, a3, s);
            bzd_pkg::ORD_VEL:  v = poly_round(a1, 2 * a2, 3 * a3, 0, s);
            bzd_pkg::ORD_ACC:  v = poly_round(2 * a2, 6 * a3, 0, 0, s);
            bzd_pkg::ORD_JERK: v = 6 * a3;
            // Orders beyond the third derivative give a zero vector.
            default:           v = 0;
         endcase
         lanes[j] = saturate(v);
      end
      return '{x: lanes[0], y: lanes[1], z: lanes[2]};
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   function automatic void check_field(input string name,
                                       input logic signed [bzd_pkg::OUT_W-1:0] want,
                                       input logic signed [bzd_pkg::OUT_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Every request transaction that the block accepts has its curve value
   // queued at the accepting edge, and every result strobe is matched with
   // the oldest value still owed. Queueing comes first, so that even a very
   // short pipeline could not overtake its own prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            pending_curve_values.insert(pending_curve_values.size(),
                                        curve_value(req_cmd, req_param_t));
         if (rsp_valid) begin
            if (pending_curve_values.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected, actual x %0d y %0d z %0d",
                        $time, rsp_out_x, rsp_out_y, rsp_out_z);
            end else begin
               owed_value = pending_curve_values.pop_front();
               check_field("out_x", owed_value.x, rsp_out_x);
               check_field("out_y", owed_value.y, rsp_out_y);
               check_field("out_z", owed_value.z, rsp_out_z);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared driving tasks
   // ---------------------------------------------------------------------

   // Presents one request and returns at the edge that accepts it. start is
   // left high, so that a following request goes out with no gap; any gap
   // is made by the caller lowering start in a later time step.
   task automatic send_request(input logic [bzd_pkg::CMD_W-1:0] cmd,
                               input logic signed [bzd_pkg::PARAM_W-1:0] t);
      start       <= 1'b1;
      req_cmd     <= cmd;
      req_param_t <= t;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Writes one control point and updates the local copy at the edge that
   // takes the write. csr_valid is lowered afterwards, so that a second write
   // is never raised in the same time step.
   task automatic write_point(input bzd_pkg::csr_reg_type idx,
                              input logic [bzd_pkg::CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      ctrl_points[idx] = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_points(input logic [bzd_pkg::CFG_W-1:0] p0,
                              input logic [bzd_pkg::CFG_W-1:0] p1,
                              input logic [bzd_pkg::CFG_W-1:0] p2,
                              input logic [bzd_pkg::CFG_W-1:0] p3);
      write_point(bzd_pkg::REG_POINT_ZERO, p0);
      write_point(bzd_pkg::REG_POINT_ONE, p1);
      write_point(bzd_pkg::REG_POINT_TWO, p2);
      write_point(bzd_pkg::REG_POINT_THREE, p3);
   endtask

   // Stops sending and waits until every owed result has come back, then
   // lets the pipeline settle before the control points may change.
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_curve_values.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A coordinate that is often one of the corners of its range.
   function automatic logic [COORD_BITS-1:0] random_coord;
      case ($urandom_range(0, 5))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3:       return COORD_NEG;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [bzd_pkg::CFG_W-1:0] random_point;
      logic [bzd_pkg::CFG_W-1:0] word;
      word = {random_coord(), random_coord(), random_coord()};
      return word;
   endfunction

   // Mostly parameters inside the unit interval, with a share taken from the
   // whole signed range so that both clamps are often hit.
   function automatic logic signed [bzd_pkg::PARAM_W-1:0] random_param;
      case ($urandom_range(0, 9))
         0, 1:    return bzd_pkg::PARAM_W'($urandom);
         2:       return $urandom_range(0, 1) ? T_ONE[bzd_pkg::PARAM_W-1:0] : '0;
         default: return bzd_pkg::PARAM_W'($urandom_range(0, 32'(T_ONE)));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // After reset all control points are zero, so every order at every
   // parameter must give the zero vector.
   task automatic test_reset_points;
      for (int n = 0; n < bzd_pkg::CMD_W * 3; n++)
         send_request(bzd_pkg::CMD_W'(n), random_param());
      drain();
   endtask

   // Corner control points, with most coordinates at one end of their range,
   // give the largest derivatives that the block can produce. Every order,
   // including those beyond the third derivative, is sent, while the
   // parameter steps through its corners: both ends of the signed range, just
   // either side of zero and of one, and the midpoint.
   task automatic test_directed_corners;
      logic signed [bzd_pkg::PARAM_W-1:0] corner_params [9];
      corner_params = '{
         {1'b1, {(bzd_pkg::PARAM_W-1){1'b0}}},
         -18'sd1,
         18'sd0,
         18'sd1,
         T_ONE[bzd_pkg::PARAM_W-1:0] >>> 1,
         T_ONE[bzd_pkg::PARAM_W-1:0] - 18'sd1,
         T_ONE[bzd_pkg::PARAM_W-1:0],
         T_ONE[bzd_pkg::PARAM_W-1:0] + 18'sd1,
         {1'b0, {(bzd_pkg::PARAM_W-1){1'b1}}}
      };
      load_points({COORD_MAX, COORD_MIN, COORD_MAX},
                  {COORD_MIN, COORD_MAX, COORD_MIN},
                  {COORD_MAX, COORD_MIN, COORD_NEG},
                  {COORD_MIN, COORD_MAX, COORD_BITS'(1)});
      for (int n = 0; n < 24; n++)
         send_request(bzd_pkg::CMD_W'(n % 8), corner_params[n % 9]);
      drain();
   endtask

   // One phase of random curves: fresh control points, then a run of random
   // requests. Where idling is on, start drops for bursts at random points,
   // and how often it does so varies from phase to phase.
   task automatic test_random_curves(input int count, input bit with_idle);
      int idle_odds;
      load_points(random_point(), random_point(), random_point(), random_point());
      idle_odds = $urandom_range(2, 8);
      for (int n = 0; n < count; n++) begin
         if (with_idle && $urandom_range(1, idle_odds) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         send_request(bzd_pkg::CMD_W'($urandom_range(0, 7)), random_param());
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_points();
      test_directed_corners();
      for (int phase = 0; phase < 4; phase++)
         test_random_curves(110, 1'b1);
      // The closing phase runs at full rate with no gaps at all.
      test_random_curves(110, 1'b0);

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
